>>> src/breath_flow_pressure_monitor_unit_defines.svh
// assertion macros for the breath flow and pressure monitor
`ifndef BREATH_FLOW_PRESSURE_MONITOR_UNIT_DEFINES_SVH
`define BREATH_FLOW_PRESSURE_MONITOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define BFPM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfpm: same-cycle check failed");
// next-cycle implication
`define BFPM_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfpm: next-cycle check failed");
`else
`define BFPM_ASSERT_IMP(label, clk, rst, ante, cons)
`define BFPM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

>>> src/bfpm_pkg.sv
package bfpm_pkg;

  // accumulator width default
  localparam int ACC_WIDTH_DEFAULT = 48;

  // result queue depth, also the number of beats allowed in flight
  localparam int OUT_DEPTH = 8;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 24;
  localparam int VOL_GAIN_W  = 24;

  // event codes
  localparam logic [2:0] MODE_PRESSURE   = 3'd0;
  localparam logic [2:0] MODE_FLOW       = 3'd1;
  localparam logic [2:0] MODE_END_BREATH = 3'd2;
  localparam logic [2:0] MODE_RST_EXTREM = 3'd3;
  localparam logic [2:0] MODE_RST_VOLUME = 3'd4;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FLOW_OFFSET = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FLOW_GAIN   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME_GAIN = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_STALL_LIMIT = 8'd3;

  // register reset values
  localparam logic [15:0] FLOW_OFFSET_RST = 16'd32768;
  localparam logic [23:0] FLOW_GAIN_RST   = 24'd139810;
  localparam logic [23:0] VOLUME_GAIN_RST = 24'd596523;
  localparam logic [7:0]  STALL_LIMIT_RST = 8'd10;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] pressure_sample;
    logic [15:0] flow_raw;
    logic        flow_crc_ok;
    logic [15:0] elapsed_ms;
  } bfpm_in_t;

  typedef struct packed {
    logic signed [15:0] flow_lpm_q8;
    logic               flow_valid;
    logic               stalled;
    logic [15:0]        running_min;
    logic [15:0]        running_max;
    logic [15:0]        breath_min;
    logic [15:0]        breath_max;
    logic signed [23:0] breath_volume_ml;
  } bfpm_out_t;

endpackage

>>> src/breath_flow_pressure_monitor_unit.sv
// Breath flow and pressure monitor. Each beat on the sample channel is one event
// (pressure sample, flow sample, end of breath, reset of extremes, reset of volume)
// and gives exactly one beat on the result channel, in order. A new sample beat
// is taken every clock while sample_stall is low. The result passes through the
// register stages: input register, multiply (offset-corrected flow times flow
// gain and times elapsed time), state update, two stages for the low and high
// halves of the accumulator times volume gain, and the final add and saturation
// written into the result queue. Results wait in an eight-beat queue, so up to
// eight beats may be outstanding; sample_stall rises only when all eight are in
// use. Registers are written through the cfg channel, which is always ready;
// writes to indexes beyond the four registers are ignored. Write registers only
// while no beat is in flight.
`include "breath_flow_pressure_monitor_unit_defines.svh"

module breath_flow_pressure_monitor_unit #(
  parameter int ACC_WIDTH = bfpm_pkg::ACC_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  bfpm_pkg::bfpm_in_t                  sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output bfpm_pkg::bfpm_out_t                 result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bfpm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bfpm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bfpm_pkg::*;

  // widths of the volume product pieces
  localparam int HI_W  = ACC_WIDTH - 32;
  localparam int HP_W  = HI_W + VOL_GAIN_W;
  localparam int R_W   = HP_W + 1;
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int PTR_W = $clog2(OUT_DEPTH);

  // configuration registers
  logic [15:0] flow_offset;
  logic [23:0] flow_gain;
  logic [23:0] volume_gain;
  logic [7:0]  stall_limit;

  // monitor state
  logic [15:0]                min_seen;
  logic [15:0]                max_seen;
  logic [15:0]                prev_flow_raw;
  logic [7:0]                 repeat_count;
  logic                       flow_ok_flag;
  logic signed [15:0]         current_flow;
  logic signed [ACC_WIDTH-1:0] volume_acc;
  logic signed [23:0]         latched_volume;
  logic [15:0]                latched_min;
  logic [15:0]                latched_max;

  logic accept_in;
  logic out_accept;

  assign accept_in  = sample_valid && !sample_stall;
  assign out_accept = result_valid && !result_stall;
  assign cfg_ready  = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      flow_offset <= FLOW_OFFSET_RST;
      flow_gain   <= FLOW_GAIN_RST;
      volume_gain <= VOLUME_GAIN_RST;
      stall_limit <= STALL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FLOW_OFFSET: flow_offset <= cfg_data[15:0];
        CFG_FLOW_GAIN:   flow_gain   <= cfg_data[23:0];
        CFG_VOLUME_GAIN: volume_gain <= cfg_data[23:0];
        CFG_STALL_LIMIT: stall_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stage 0: input register
  // ---------------------------------------------------------------------------
  logic     v0;
  bfpm_in_t s0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= accept_in;
    end
    if (accept_in) begin
      s0 <= sample;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: offset removal and the two products that need no state
  // ---------------------------------------------------------------------------
  logic signed [16:0] delta_a;
  logic signed [41:0] pflow_a;
  logic signed [33:0] pvol_a;

  assign delta_a = $signed({1'b0, s0.flow_raw}) - $signed({1'b0, flow_offset});
  assign pflow_a = delta_a * $signed({1'b0, flow_gain});
  assign pvol_a  = delta_a * $signed({1'b0, s0.elapsed_ms});

  logic               v1;
  logic [2:0]         s1_mode;
  logic [15:0]        s1_pres;
  logic [15:0]        s1_raw;
  logic               s1_crc;
  logic               s1_delta_nz;
  logic signed [25:0] s1_q;
  logic signed [33:0] s1_pvol;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    s1_mode     <= s0.mode;
    s1_pres     <= s0.pressure_sample;
    s1_raw      <= s0.flow_raw;
    s1_crc      <= s0.flow_crc_ok;
    s1_delta_nz <= (delta_a != 17'sd0);
    // arithmetic shift gives the floor of the division by 2^16
    s1_q        <= pflow_a[41:16];
  end

  always_ff @(posedge clk) begin
    s1_pvol <= pvol_a;
  end

  // ---------------------------------------------------------------------------
  // stage 2: state update, all events in order
  // ---------------------------------------------------------------------------
  logic [15:0]                 min_next;
  logic [15:0]                 max_next;
  logic [15:0]                 prev_next;
  logic [7:0]                  repeat_next;
  logic                        flow_ok_next;
  logic signed [15:0]          flow_next;
  logic signed [ACC_WIDTH-1:0] acc_next;
  logic [15:0]                 lmin_next;
  logic [15:0]                 lmax_next;
  logic                        stall_b;
  logic signed [ACC_WIDTH:0]   acc_sum;
  logic signed [ACC_WIDTH-1:0] acc_sat;
  logic signed [15:0]          flow_sat;
  logic [7:0]                  rep;

  assign acc_sum = {volume_acc[ACC_WIDTH-1], volume_acc} + (ACC_WIDTH + 1)'(s1_pvol);

  // saturate the accumulator on overflow of the signed range
  always_comb begin
    if (acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1]) begin
      acc_sat = acc_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                   : {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[ACC_WIDTH-1:0];
    end
  end

  always_comb begin
    if (s1_q > 26'sd32767) begin
      flow_sat = 16'sh7FFF;
    end else if (s1_q < -26'sd32768) begin
      flow_sat = 16'sh8000;
    end else begin
      flow_sat = s1_q[15:0];
    end
  end

  always_comb begin
    min_next     = min_seen;
    max_next     = max_seen;
    prev_next    = prev_flow_raw;
    repeat_next  = repeat_count;
    flow_ok_next = flow_ok_flag;
    flow_next    = current_flow;
    acc_next     = volume_acc;
    lmin_next    = latched_min;
    lmax_next    = latched_max;
    stall_b      = 1'b0;
    rep          = 8'd0;
    case (s1_mode)
      MODE_PRESSURE: begin
        if (s1_pres < min_seen) begin
          min_next = s1_pres;
        end
        if (s1_pres > max_seen) begin
          max_next = s1_pres;
        end
      end
      MODE_FLOW: begin
        flow_ok_next = s1_crc;
        // repeats count only for identical readings away from zero flow
        if ((s1_raw == prev_flow_raw) && s1_delta_nz) begin
          rep = (repeat_count != 8'hFF) ? repeat_count + 8'd1 : repeat_count;
        end
        if (rep > stall_limit) begin
          stall_b = 1'b1;
          rep     = 8'd0;
        end
        repeat_next = rep;
        prev_next   = s1_raw;
        flow_next   = flow_sat;
        acc_next    = acc_sat;
      end
      MODE_END_BREATH: begin
        lmin_next = min_seen;
        lmax_next = max_seen;
      end
      MODE_RST_EXTREM: begin
        min_next = '1;
        max_next = '0;
      end
      MODE_RST_VOLUME: begin
        acc_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_seen      <= '1;
      max_seen      <= '0;
      prev_flow_raw <= '0;
      repeat_count  <= '0;
      flow_ok_flag  <= 1'b0;
      current_flow  <= '0;
      volume_acc    <= '0;
      latched_min   <= '0;
      latched_max   <= '0;
    end else if (v1) begin
      min_seen      <= min_next;
      max_seen      <= max_next;
      prev_flow_raw <= prev_next;
      repeat_count  <= repeat_next;
      flow_ok_flag  <= flow_ok_next;
      current_flow  <= flow_next;
      volume_acc    <= acc_next;
      latched_min   <= lmin_next;
      latched_max   <= lmax_next;
    end
  end

  // partial result plus a sign and magnitude snapshot of the accumulator
  logic                 v2;
  bfpm_out_t            s2_res;
  logic                 s2_end;
  logic                 s2_neg;
  logic [ACC_WIDTH-1:0] s2_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    s2_res.flow_lpm_q8      <= flow_next;
    s2_res.flow_valid       <= flow_ok_next;
    s2_res.stalled          <= stall_b;
    s2_res.running_min      <= min_next;
    s2_res.running_max      <= max_next;
    s2_res.breath_min       <= lmin_next;
    s2_res.breath_max       <= lmax_next;
    s2_res.breath_volume_ml <= '0;
    s2_end                  <= (s1_mode == MODE_END_BREATH);
    s2_neg                  <= volume_acc[ACC_WIDTH-1];
    s2_mag                  <= volume_acc[ACC_WIDTH-1] ? ACC_WIDTH'(-volume_acc)
                                                       : ACC_WIDTH'(volume_acc);
  end

  // ---------------------------------------------------------------------------
  // stage 3: low half of the magnitude times volume gain
  // ---------------------------------------------------------------------------
  logic                              v3;
  bfpm_out_t                         s3_res;
  logic                              s3_end;
  logic                              s3_neg;
  logic [HI_W-1:0]                   s3_hi;
  logic [32+VOL_GAIN_W-1:0]          s3_lp;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    s3_res <= s2_res;
    s3_end <= s2_end;
    s3_neg <= s2_neg;
    s3_hi  <= s2_mag[ACC_WIDTH-1:32];
    s3_lp  <= (32 + VOL_GAIN_W)'(s2_mag[31:0]) * (32 + VOL_GAIN_W)'(volume_gain);
  end

  // ---------------------------------------------------------------------------
  // stage 4: high half times volume gain
  // ---------------------------------------------------------------------------
  logic              v4;
  bfpm_out_t         s4_res;
  logic              s4_end;
  logic              s4_neg;
  logic [HP_W-1:0]   s4_hp;
  logic [23:0]       s4_lp_hi;
  logic              s4_round;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    s4_res   <= s3_res;
    s4_end   <= s3_end;
    s4_neg   <= s3_neg;
    s4_hp    <= HP_W'(s3_hi) * HP_W'(volume_gain);
    s4_lp_hi <= s3_lp[32+VOL_GAIN_W-1:32];
    // a negative value with dropped bits rounds away from zero in magnitude
    s4_round <= s3_neg && (s3_lp[31:0] != 32'd0);
  end

  // ---------------------------------------------------------------------------
  // stage 5: final add, saturation to 24 bits, into the result queue
  // ---------------------------------------------------------------------------
  logic [R_W-1:0]     vol_mag;
  logic signed [23:0] vol;
  bfpm_out_t          res_e;

  assign vol_mag = R_W'(s4_hp) + R_W'(s4_lp_hi) + R_W'(s4_round);

  always_comb begin
    if (s4_neg) begin
      if (vol_mag > R_W'(24'h800000)) begin
        vol = 24'sh800000;
      end else begin
        vol = 24'(24'd0 - vol_mag[23:0]);
      end
    end else begin
      if (vol_mag > R_W'(24'h7FFFFF)) begin
        vol = 24'sh7FFFFF;
      end else begin
        vol = vol_mag[23:0];
      end
    end
  end

  always_comb begin
    res_e                  = s4_res;
    res_e.breath_volume_ml = s4_end ? vol : latched_volume;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_volume <= '0;
    end else if (v4 && s4_end) begin
      latched_volume <= vol;
    end
  end

  // result queue, credit counted from the input side so it never overflows
  bfpm_out_t        fifo_mem [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fifo_cnt;
  logic [CNT_W-1:0] inflight;

  always_ff @(posedge clk) begin
    if (v4) begin
      fifo_mem[wr_ptr] <= res_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
      inflight <= '0;
    end else begin
      if (v4) begin
        wr_ptr <= (wr_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (out_accept) begin
        rd_ptr <= (rd_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({v4, out_accept})
        2'b10:   fifo_cnt <= fifo_cnt + CNT_W'(1);
        2'b01:   fifo_cnt <= fifo_cnt - CNT_W'(1);
        default: fifo_cnt <= fifo_cnt;
      endcase
      case ({accept_in, out_accept})
        2'b10:   inflight <= inflight + CNT_W'(1);
        2'b01:   inflight <= inflight - CNT_W'(1);
        default: inflight <= inflight;
      endcase
    end
  end

  assign result_valid = (fifo_cnt != '0);
  assign result       = fifo_mem[rd_ptr];
  assign sample_stall = (inflight == CNT_W'(OUT_DEPTH));

  // queue occupancy stays within the credits handed out
  `BFPM_ASSERT_IMP(a_fifo_within_credit, clk, rst, 1'b1, fifo_cnt <= inflight)
  // a lone accepted beat takes one credit
  `BFPM_ASSERT_NXT(a_credit_taken, clk, rst, accept_in && !out_accept, inflight == $past(inflight) + CNT_W'(1))
  // a stall report clears the repeat count
  `BFPM_ASSERT_NXT(a_stall_clears_count, clk, rst, v1 && stall_b, repeat_count == 8'd0)

endmodule
